### rtl/msh_pkg.sv
// Package for the escape-time pixel shade pipeline.
// Holds the stage word type, register index codes and the saturation helper.
// No dependencies.
package msh_pkg;

    localparam int QW = 32;
    localparam int NW = 8;

    localparam logic [0:0] REG_STEP_X = 1'b0;
    localparam logic [0:0] REG_STEP_Y = 1'b1;

    localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [QW-1:0] zx;
        logic signed [QW-1:0] zy;
        logic signed [QW-1:0] cx;
        logic signed [QW-1:0] cy;
        logic [NW-1:0]        n;
        logic [7:0]           gain;
        logic                 done;
        logic [7:0]           red;
        logic [7:0]           green;
        logic [7:0]           blue;
    } item_t;

    function automatic logic signed [QW-1:0] sat32(input logic signed [63:0] v);
        logic signed [QW-1:0] r;
        if (v > Q_MAX)
        begin
            r = Q_MAX[QW-1:0];
        end
        else if (v < Q_MIN)
        begin
            r = Q_MIN[QW-1:0];
        end
        else
        begin
            r = v[QW-1:0];
        end
        return r;
    endfunction

endpackage

### rtl/msh_map.sv
// Coordinate mapping: two stages turning pixel position into the point c.
// Depends on msh_pkg.
module msh_map #(
    parameter int FRAC_BITS  = 26,
    parameter int COORD_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [11:0]          pixel_x,
    input  logic [11:0]          pixel_y,
    input  logic [7:0]           red_in,
    input  logic [7:0]           green_in,
    input  logic [7:0]           blue_in,
    input  logic [27:0]          step_x,
    input  logic [26:0]          step_y,
    output logic                 out_valid,
    output msh_pkg::item_t       out_item
);

    localparam logic [11:0] CMASK = (COORD_BITS >= 12) ? 12'hFFF
                                                       : 12'((1 << COORD_BITS) - 1);
    localparam logic signed [63:0] TWO  = 64'sd2 <<< FRAC_BITS;
    localparam logic [63:0]        C095 = ((64'd95 << FRAC_BITS) + 64'd50) / 64'd100;

    logic        a_valid_reg;
    logic [39:0] prx_reg;
    logic [38:0] pry_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic        b_valid_reg;
    msh_pkg::item_t item_reg;
    msh_pkg::item_t item_next;

    logic [11:0] px;
    logic [11:0] py;

    assign px = pixel_x & CMASK;
    assign py = pixel_y & CMASK;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prx_reg   <= 40'(px) * 40'(step_x);
            pry_reg   <= 39'(py) * 39'(step_y);
            red_reg   <= red_in;
            green_reg <= green_in;
            blue_reg  <= blue_in;
            item_reg  <= item_next;
        end
    end

    always_comb
    begin
        item_next       = '0;
        item_next.cx    = msh_pkg::sat32(signed'({24'b0, prx_reg}) - TWO);
        item_next.cy    = msh_pkg::sat32(signed'({25'b0, pry_reg}) - signed'(C095));
        item_next.red   = red_reg;
        item_next.green = green_reg;
        item_next.blue  = blue_reg;
    end

    assign out_valid = b_valid_reg;
    assign out_item  = item_reg;

endmodule

### rtl/msh_iter.sv
// One z = z*z + c iteration: a multiply stage then an add and saturate stage.
// Depends on msh_pkg.
module msh_iter #(
    parameter int FRAC_BITS = 26,
    parameter int STAGE     = 0
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  msh_pkg::item_t in_item,
    output logic           out_valid,
    output msh_pkg::item_t out_item
);

    localparam logic [63:0] LIMIT = 64'd10 << (2 * FRAC_BITS);
    localparam logic [7:0]  GAIN_ADD = 8'(STAGE + 1);
    localparam logic [msh_pkg::NW-1:0] N_NEXT = msh_pkg::NW'(STAGE + 1);

    logic                 a_valid_reg;
    logic signed [63:0]   xx_reg;
    logic signed [63:0]   yy_reg;
    logic signed [63:0]   xy_reg;
    msh_pkg::item_t       a_item_reg;
    logic                 b_valid_reg;
    msh_pkg::item_t       b_item_reg;
    msh_pkg::item_t       b_item_next;

    logic signed [63:0] xx_next;
    logic signed [63:0] yy_next;
    logic signed [63:0] xy_next;
    logic [63:0]        mag;
    logic signed [63:0] diff;
    logic               run;

    assign xx_next = 64'(in_item.zx) * 64'(in_item.zx);
    assign yy_next = 64'(in_item.zy) * 64'(in_item.zy);
    assign xy_next = 64'(in_item.zx) * 64'(in_item.zy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg     <= xx_next;
            yy_reg     <= yy_next;
            xy_reg     <= xy_next;
            a_item_reg <= in_item;
            b_item_reg <= b_item_next;
        end
    end

    assign mag  = 64'(xx_reg) + 64'(yy_reg);
    assign diff = xx_reg - yy_reg;
    assign run  = !a_item_reg.done && (mag < LIMIT);

    always_comb
    begin
        b_item_next = a_item_reg;
        if (run)
        begin
            b_item_next.zx   = msh_pkg::sat32((diff >>> FRAC_BITS) + 64'(a_item_reg.cx));
            b_item_next.zy   = msh_pkg::sat32((xy_reg >>> (FRAC_BITS - 1))
                                              + 64'(a_item_reg.cy));
            b_item_next.n    = N_NEXT;
            b_item_next.gain = a_item_reg.gain + GAIN_ADD;
        end
        else
        begin
            b_item_next.done = 1'b1;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

endmodule

### rtl/mandelbrot_pixel_shade.sv
// Top level of the escape-time pixel shade: config registers, mapping,
// MAX_ITER iteration slices and the output register. Depends on msh_pkg,
// msh_map and msh_iter.
//
//   channel | direction | handshake            | payload
//   s_axis  | in        | s_tvalid / s_tready  | s_tdata: pixel, colour word
//   m_axis  | out       | m_tvalid / m_tready  | m_tdata: shaded colour word
//   cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One word enters per cycle while m_axis is not stalled; the path runs through two
// register stages for mapping, two per iteration slice and the output register.
// Reset clears the valid bits and loads the default steps.
// A stall at m_axis freezes every stage together; s_tready falls with it.
module mandelbrot_pixel_shade #(
    parameter int MAX_ITER   = 50,
    parameter int FRAC_BITS  = 26,
    parameter int COORD_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pixel_x, pixel_y, red_in, green_in, blue_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // red_out, green_out, blue_out, iteration_count, pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [27:0] cfg_data
);

    logic [27:0] step_x_reg;
    logic [26:0] step_y_reg;
    logic        en;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic [31:0] out_data_next;

    logic           chain_valid [0:MAX_ITER];
    msh_pkg::item_t chain_item  [0:MAX_ITER];

    assign en        = !out_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_x_reg <= 28'd163840;
            step_y_reg <= 27'd166024;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                msh_pkg::REG_STEP_X: step_x_reg <= cfg_data;
                msh_pkg::REG_STEP_Y: step_y_reg <= cfg_data[26:0];
                default: ;
            endcase
        end
    end

    msh_map #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .pixel_x   (s_tdata[11:0]),
        .pixel_y   (s_tdata[23:12]),
        .red_in    (s_tdata[31:24]),
        .green_in  (s_tdata[39:32]),
        .blue_in   (s_tdata[47:40]),
        .step_x    (step_x_reg),
        .step_y    (step_y_reg),
        .out_valid (chain_valid[0]),
        .out_item  (chain_item[0])
    );

    for (genvar k = 0; k < MAX_ITER; k++)
    begin : g_iter
        msh_iter #(
            .FRAC_BITS (FRAC_BITS),
            .STAGE     (k)
        ) u_iter (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (chain_valid[k]),
            .in_item   (chain_item[k]),
            .out_valid (chain_valid[k+1]),
            .out_item  (chain_item[k+1])
        );
    end

    always_comb
    begin
        out_data_next        = '0;
        out_data_next[7:0]   = chain_item[MAX_ITER].red   + chain_item[MAX_ITER].gain;
        out_data_next[15:8]  = chain_item[MAX_ITER].green + chain_item[MAX_ITER].gain;
        out_data_next[23:16] = chain_item[MAX_ITER].blue  + chain_item[MAX_ITER].gain;
        out_data_next[29:24] = chain_item[MAX_ITER].n[5:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= chain_valid[MAX_ITER];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### rtl/msh_checker.sv
// Port-level checks for the pixel shade top level, attached by bind.
// Depends only on the top level's ports and its MAX_ITER parameter.
module msh_checker #(
    parameter int MAX_ITER = 50
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    localparam logic [5:0] N_MAX = 6'(MAX_ITER);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((MAX_ITER > 63) || (m_tdata[29:24] <= N_MAX)))
        else $error("iteration count above limit");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[31:30] == 2'b00))
        else $error("padding bits set");

    a_ready_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready not tied to output stall");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled word changed");

endmodule

bind mandelbrot_pixel_shade msh_checker #(
    .MAX_ITER (MAX_ITER)
) u_msh_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
